// ===== rtl/rvm_pkg.sv =====
package rvm_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int CORDIC_STAGES = 24;

    // Pipeline depths
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 31;
    localparam int ANG_STAGES  = CORDIC_STAGES + 2;
    localparam int MID_STAGES  = (ANG_STAGES > DIV_STAGES) ? ANG_STAGES : DIV_STAGES;

    // Angle / CORDIC datapath width
    localparam int CW = 36;

    localparam logic signed [CW-1:0] ONE_Q30     = 36'sd1073741824;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [CW-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [CW-1:0] FOUR_PI_Q30 = 36'sd13493037704;
    localparam logic signed [CW-1:0] GAIN_Q30    = 36'sd652032874;

    // Norm stage result
    typedef struct packed {
        logic               zero;
        logic [31:0]        norm;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
    } rvm_norm_t;

    // Axis and angle result
    typedef struct packed {
        logic               zero;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic signed [31:0] uz;
        logic signed [31:0] c;
        logic signed [31:0] s;
    } rvm_rot_t;

    // atan(2^-i) in Q.30, truncated
    function automatic logic signed [CW-1:0] atan_q30(input int i);
        logic signed [CW-1:0] r;
        case (i)
            0:       r = 36'sd843314856;
            1:       r = 36'sd497837829;
            2:       r = 36'sd263043836;
            3:       r = 36'sd133525158;
            4:       r = 36'sd67021686;
            5:       r = 36'sd33543515;
            6:       r = 36'sd16775850;
            7:       r = 36'sd8388437;
            8:       r = 36'sd4194282;
            9:       r = 36'sd2097149;
            default:
            begin
                if (i <= 30)
                    r = CW'((64'd1 << (30 - i)) - 64'd1);
                else
                    r = '0;
            end
        endcase
        return r;
    endfunction

    // Q1.30 product back to Q1.30, round half up
    function automatic logic signed [33:0] rnd_q30(input logic signed [67:0] p);
        logic signed [67:0] r;
        r = (p + 68'sd536870912) >>> 30;
        return r[33:0];
    endfunction

    // Clamp to [-1.0, 1.0] in Q1.30
    function automatic logic signed [31:0] clamp_one(input logic signed [CW-1:0] v);
        logic signed [31:0] r;
        if (v > ONE_Q30)
            r = 32'sd1073741824;
        else if (v < -ONE_Q30)
            r = -32'sd1073741824;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== rtl/rvm_vec_if.sv =====
interface rvm_vec_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [rvm_pkg::DATA_WIDTH-1:0]    rot_x;
    logic signed [rvm_pkg::DATA_WIDTH-1:0]    rot_y;
    logic signed [rvm_pkg::DATA_WIDTH-1:0]    rot_z;

    modport source (output valid, rot_x, rot_y, rot_z, input ready);
    modport sink   (input valid, rot_x, rot_y, rot_z, output ready);
endinterface

// ===== rtl/rvm_mat_if.sv =====
interface rvm_mat_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

// ===== rtl/rvm_norm.sv =====
module rvm_norm (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [rvm_pkg::DATA_WIDTH-1:0] rot_x,
    input  logic signed [rvm_pkg::DATA_WIDTH-1:0] rot_y,
    input  logic signed [rvm_pkg::DATA_WIDTH-1:0] rot_z,
    output logic                                  out_valid,
    output rvm_pkg::rvm_norm_t                    out_norm
);

    localparam int DW  = rvm_pkg::DATA_WIDTH;
    localparam int NS  = rvm_pkg::SQRT_STAGES;
    localparam int SHR = (DW >= 32) ? DW - 32 : 0;
    localparam int SHL = (DW < 32) ? 32 - DW : 0;

    typedef struct packed {
        logic [63:0]        rem;
        logic [63:0]        root;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
    } sq_t;

    // Bring an input to Q3.28
    function automatic logic signed [31:0] to_q28(input logic signed [DW-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        if (DW >= 32)
            w = w >>> SHR;
        else
            w = w <<< SHL;
        return w[31:0];
    endfunction

    logic signed [31:0] qx, qy, qz;
    logic signed [63:0] px, py, pz;

    logic               sq_vld_reg;
    logic [63:0]        sqx_reg, sqy_reg, sqz_reg;
    logic signed [31:0] vx_reg, vy_reg, vz_reg;

    logic [NS:0]        vld_reg;
    sq_t                st_reg  [NS+1];
    sq_t                st_next [NS+1];

    // Squares
    assign qx = to_q28(rot_x);
    assign qy = to_q28(rot_y);
    assign qz = to_q28(rot_z);
    assign px = qx * qx;
    assign py = qy * qy;
    assign pz = qz * qz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg <= 1'b0;
        else if (en)
            sq_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= $unsigned(px);
            sqy_reg <= $unsigned(py);
            sqz_reg <= $unsigned(pz);
            vx_reg  <= qx;
            vy_reg  <= qy;
            vz_reg  <= qz;
        end
    end

    // Sum, then one root bit per stage
    always_comb
    begin
        logic [63:0] trial;
        logic [63:0] bitv;
        st_next[0].rem  = sqx_reg + sqy_reg + sqz_reg;
        st_next[0].root = '0;
        st_next[0].vx   = vx_reg;
        st_next[0].vy   = vy_reg;
        st_next[0].vz   = vz_reg;
        for (int k = 0; k < NS; k++)
        begin
            bitv          = 64'd1 << (62 - 2 * k);
            trial         = st_reg[k].root + bitv;
            st_next[k+1]  = st_reg[k];
            if (st_reg[k].rem >= trial)
            begin
                st_next[k+1].rem  = st_reg[k].rem - trial;
                st_next[k+1].root = (st_reg[k].root >> 1) + bitv;
            end
            else
            begin
                st_next[k+1].root = st_reg[k].root >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NS-1:0], sq_vld_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= NS; k++)
                st_reg[k] <= st_next[k];
        end
    end

    assign out_valid     = vld_reg[NS];
    assign out_norm.zero = (st_reg[NS].root == 64'd0);
    assign out_norm.norm = st_reg[NS].root[31:0];
    assign out_norm.vx   = st_reg[NS].vx;
    assign out_norm.vy   = st_reg[NS].vy;
    assign out_norm.vz   = st_reg[NS].vz;

endmodule

// ===== rtl/rvm_axang.sv =====
module rvm_axang (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  rvm_pkg::rvm_norm_t in_norm,
    output logic               out_valid,
    output rvm_pkg::rvm_rot_t  out_rot
);

    localparam int NM = rvm_pkg::MID_STAGES;
    localparam int CW = rvm_pkg::CW;

    typedef struct packed {
        logic                 zero;
        logic [31:0]          n;
        logic [2:0]           neg;
        logic [33:0]          r0;
        logic [33:0]          r1;
        logic [33:0]          r2;
        logic [30:0]          q0;
        logic [30:0]          q1;
        logic [30:0]          q2;
        logic                 flip;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } ms_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // One restoring divide step: {quotient, remainder}
    function automatic logic [64:0] div_step(input logic [33:0] r, input logic [30:0] q,
                                             input logic [31:0] n, input logic shift);
        logic [33:0] t;
        t = shift ? {r[32:0], 1'b0} : r;
        if (t >= {2'b00, n})
            return {q[29:0], 1'b1, t - {2'b00, n}};
        else
            return {q[29:0], 1'b0, t};
    endfunction

    logic [NM:0] vld_reg;
    ms_t         st_reg  [NM+1];
    ms_t         st_next [NM+1];

    logic               rot_vld_reg;
    rvm_pkg::rvm_rot_t  rot_reg;
    rvm_pkg::rvm_rot_t  rot_next;

    always_comb
    begin
        logic signed [CW-1:0] b;
        logic                 fl;
        logic [64:0]          d0, d1, d2;

        b  = '0;
        fl = 1'b0;
        d0 = '0;
        d1 = '0;
        d2 = '0;

        // Entry
        st_next[0].zero = in_norm.zero;
        st_next[0].n    = in_norm.zero ? 32'd1 : in_norm.norm;
        st_next[0].neg  = {in_norm.vz[31], in_norm.vy[31], in_norm.vx[31]};
        st_next[0].r0   = {2'b00, mag32(in_norm.vx)};
        st_next[0].r1   = {2'b00, mag32(in_norm.vy)};
        st_next[0].r2   = {2'b00, mag32(in_norm.vz)};
        st_next[0].q0   = '0;
        st_next[0].q1   = '0;
        st_next[0].q2   = '0;
        st_next[0].flip = 1'b0;
        st_next[0].x    = '0;
        st_next[0].y    = '0;
        st_next[0].z    = $signed(CW'({in_norm.norm, 2'b00}));

        for (int k = 0; k < NM; k++)
        begin
            st_next[k+1] = st_reg[k];

            // Axis lanes
            if (k < rvm_pkg::DIV_STAGES)
            begin
                d0 = div_step(st_reg[k].r0, st_reg[k].q0, st_reg[k].n, k != 0);
                d1 = div_step(st_reg[k].r1, st_reg[k].q1, st_reg[k].n, k != 0);
                d2 = div_step(st_reg[k].r2, st_reg[k].q2, st_reg[k].n, k != 0);
                {st_next[k+1].q0, st_next[k+1].r0} = d0;
                {st_next[k+1].q1, st_next[k+1].r1} = d1;
                {st_next[k+1].q2, st_next[k+1].r2} = d2;
            end

            // Angle lane
            if (k == 0)
            begin
                if (st_reg[k].z >= rvm_pkg::FOUR_PI_Q30)
                    st_next[k+1].z = st_reg[k].z - rvm_pkg::FOUR_PI_Q30;
                else if (st_reg[k].z >= rvm_pkg::TWO_PI_Q30)
                    st_next[k+1].z = st_reg[k].z - rvm_pkg::TWO_PI_Q30;
            end
            else if (k == 1)
            begin
                b  = st_reg[k].z;
                fl = 1'b0;
                if (b > rvm_pkg::PI_Q30)
                    b = b - rvm_pkg::TWO_PI_Q30;
                if (b > rvm_pkg::HALF_PI_Q30)
                begin
                    b  = b - rvm_pkg::PI_Q30;
                    fl = 1'b1;
                end
                else if (b < -rvm_pkg::HALF_PI_Q30)
                begin
                    b  = b + rvm_pkg::PI_Q30;
                    fl = 1'b1;
                end
                st_next[k+1].z    = b;
                st_next[k+1].flip = fl;
                st_next[k+1].x    = rvm_pkg::GAIN_Q30;
                st_next[k+1].y    = '0;
            end
            else if (k < rvm_pkg::ANG_STAGES)
            begin
                if (!st_reg[k].z[CW-1])
                begin
                    st_next[k+1].x = st_reg[k].x - (st_reg[k].y >>> (k - 2));
                    st_next[k+1].y = st_reg[k].y + (st_reg[k].x >>> (k - 2));
                    st_next[k+1].z = st_reg[k].z - rvm_pkg::atan_q30(k - 2);
                end
                else
                begin
                    st_next[k+1].x = st_reg[k].x + (st_reg[k].y >>> (k - 2));
                    st_next[k+1].y = st_reg[k].y - (st_reg[k].x >>> (k - 2));
                    st_next[k+1].z = st_reg[k].z + rvm_pkg::atan_q30(k - 2);
                end
            end
        end
    end

    // Sign the axis, unfold sin/cos
    always_comb
    begin
        logic signed [31:0] a0, a1, a2;
        a0 = $signed({1'b0, st_reg[NM].q0});
        a1 = $signed({1'b0, st_reg[NM].q1});
        a2 = $signed({1'b0, st_reg[NM].q2});
        rot_next.zero = st_reg[NM].zero;
        rot_next.ux   = st_reg[NM].neg[0] ? -a0 : a0;
        rot_next.uy   = st_reg[NM].neg[1] ? -a1 : a1;
        rot_next.uz   = st_reg[NM].neg[2] ? -a2 : a2;
        rot_next.c    = rvm_pkg::clamp_one(st_reg[NM].flip ? -st_reg[NM].x : st_reg[NM].x);
        rot_next.s    = rvm_pkg::clamp_one(st_reg[NM].flip ? -st_reg[NM].y : st_reg[NM].y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rot_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[NM-1:0], in_valid};
            rot_vld_reg <= vld_reg[NM];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= NM; k++)
                st_reg[k] <= st_next[k];
            rot_reg <= rot_next;
        end
    end

    assign out_valid = rot_vld_reg;
    assign out_rot   = rot_reg;

endmodule

// ===== rtl/rvm_matrix.sv =====
module rvm_matrix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  rvm_pkg::rvm_rot_t  in_rot,
    output logic               out_valid,
    output logic signed [31:0] m [9]
);

    localparam int CW = rvm_pkg::CW;

    logic [2:0]         vld_reg;

    // Stage 1: axis products and sin terms
    logic signed [33:0] t1_reg;
    logic signed [31:0] c1_reg;
    logic               z1_reg;
    logic signed [33:0] uu_reg [6];
    logic signed [33:0] su1_reg [3];

    // Stage 2: scaled by 1 - cos
    logic signed [31:0] c2_reg;
    logic               z2_reg;
    logic signed [33:0] tu_reg [6];
    logic signed [33:0] su2_reg [3];

    // Stage 3: entries
    logic signed [31:0] m_reg  [9];
    logic signed [31:0] m_next [9];

    always_comb
    begin
        logic signed [CW-1:0] cc;
        logic signed [CW-1:0] e [9];
        cc   = CW'(c2_reg);
        e[0] = cc + CW'(tu_reg[0]);
        e[1] = CW'(tu_reg[3]) - CW'(su2_reg[2]);
        e[2] = CW'(tu_reg[4]) + CW'(su2_reg[1]);
        e[3] = CW'(tu_reg[3]) + CW'(su2_reg[2]);
        e[4] = cc + CW'(tu_reg[1]);
        e[5] = CW'(tu_reg[5]) - CW'(su2_reg[0]);
        e[6] = CW'(tu_reg[4]) - CW'(su2_reg[1]);
        e[7] = CW'(tu_reg[5]) + CW'(su2_reg[0]);
        e[8] = cc + CW'(tu_reg[2]);
        for (int k = 0; k < 9; k++)
        begin
            if (z2_reg)
                m_next[k] = (k % 4 == 0) ? 32'sd1073741824 : 32'sd0;
            else
                m_next[k] = rvm_pkg::clamp_one(e[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg     <= 34'(rvm_pkg::ONE_Q30) - 34'(in_rot.c);
            c1_reg     <= in_rot.c;
            z1_reg     <= in_rot.zero;
            uu_reg[0]  <= rvm_pkg::rnd_q30(68'(in_rot.ux) * 68'(in_rot.ux));
            uu_reg[1]  <= rvm_pkg::rnd_q30(68'(in_rot.uy) * 68'(in_rot.uy));
            uu_reg[2]  <= rvm_pkg::rnd_q30(68'(in_rot.uz) * 68'(in_rot.uz));
            uu_reg[3]  <= rvm_pkg::rnd_q30(68'(in_rot.ux) * 68'(in_rot.uy));
            uu_reg[4]  <= rvm_pkg::rnd_q30(68'(in_rot.ux) * 68'(in_rot.uz));
            uu_reg[5]  <= rvm_pkg::rnd_q30(68'(in_rot.uy) * 68'(in_rot.uz));
            su1_reg[0] <= rvm_pkg::rnd_q30(68'(in_rot.s) * 68'(in_rot.ux));
            su1_reg[1] <= rvm_pkg::rnd_q30(68'(in_rot.s) * 68'(in_rot.uy));
            su1_reg[2] <= rvm_pkg::rnd_q30(68'(in_rot.s) * 68'(in_rot.uz));

            c2_reg <= c1_reg;
            z2_reg <= z1_reg;
            for (int k = 0; k < 6; k++)
                tu_reg[k] <= rvm_pkg::rnd_q30(68'(t1_reg) * 68'(uu_reg[k]));
            for (int k = 0; k < 3; k++)
                su2_reg[k] <= su1_reg[k];

            for (int k = 0; k < 9; k++)
                m_reg[k] <= m_next[k];
        end
    end

    assign out_valid = vld_reg[2];
    assign m         = m_reg;

endmodule

// ===== rtl/rotation_vector_to_matrix_unit.sv =====
// Channel  Dir  Payload                        Transfer
// vec      in   rot_x, rot_y, rot_z  (Q3.28)   vec.valid & vec.ready
// mat      out  m00 .. m22           (Q1.30)   mat.valid & mat.ready
//
// One vector enters per cycle while the output is not stalled. Stages in order:
// squares and sum, square root (one root bit per stage), axis divide and CORDIC,
// matrix products and sums.
// Asynchronous active-low reset clears the valid bits only.
// A stalled result freezes the whole pipeline; vec.ready drops until mat moves.
module rotation_vector_to_matrix_unit (
    input  logic      clk,
    input  logic      rst_n,
    rvm_vec_if.sink   vec,
    rvm_mat_if.source mat
);

    logic               en;
    logic               nrm_valid;
    rvm_pkg::rvm_norm_t nrm;
    logic               rot_valid;
    rvm_pkg::rvm_rot_t  rot;
    logic               mat_valid;
    logic signed [31:0] m [9];

    // Global advance: move when the output slot is free or being taken
    assign en        = !mat_valid || mat.ready;
    assign vec.ready = en;

    rvm_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vec.valid),
        .rot_x     (vec.rot_x),
        .rot_y     (vec.rot_y),
        .rot_z     (vec.rot_z),
        .out_valid (nrm_valid),
        .out_norm  (nrm)
    );

    rvm_axang u_axang (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nrm_valid),
        .in_norm   (nrm),
        .out_valid (rot_valid),
        .out_rot   (rot)
    );

    rvm_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rot_valid),
        .in_rot    (rot),
        .out_valid (mat_valid),
        .m         (m)
    );

    assign mat.valid = mat_valid;
    assign mat.m00   = m[0];
    assign mat.m01   = m[1];
    assign mat.m02   = m[2];
    assign mat.m10   = m[3];
    assign mat.m11   = m[4];
    assign mat.m12   = m[5];
    assign mat.m20   = m[6];
    assign mat.m21   = m[7];
    assign mat.m22   = m[8];

    // Stalled output must hold back the input side
    a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (mat.valid && !mat.ready) |-> !vec.ready)
        else $error("input accepted while output stalled");

    // Diagonal entries m00 and m11 stay within [-1, 1]
    a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
        mat.valid |-> (mat.m00 <= 32'sd1073741824 && mat.m00 >= -32'sd1073741824 &&
                       mat.m11 <= 32'sd1073741824 && mat.m11 >= -32'sd1073741824))
        else $error("diagonal entry out of range");

    // Off-diagonal entries m01 and m12 stay within [-1, 1]
    a_offdiag_range: assert property (@(posedge clk) disable iff (!rst_n)
        mat.valid |-> (mat.m01 <= 32'sd1073741824 && mat.m01 >= -32'sd1073741824 &&
                       mat.m12 <= 32'sd1073741824 && mat.m12 >= -32'sd1073741824))
        else $error("off-diagonal entry out of range");

endmodule
